[sv/bfa_pkg.sv]
// Shared types, constants and helpers for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  // Field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 32;
  localparam int FA_W    = 27;
  localparam int CFG_W   = 13;
  // Frame numbers: up to 21 bits (end of a range may reach 2^21 - 1)
  localparam int FRAME_W = 21;
  localparam int BYTE_W  = FRAME_W - 3;
  localparam int PAGE_SHIFT = 12;

  localparam logic [7:0]       BYTE_FULL   = 8'hFF;
  localparam logic [CFG_W-1:0] CFG_RESET   = 13'd4096;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC       = 3'd0,
    OP_FREE        = 3'd1,
    OP_RESERVE_ALL = 3'd2,
    OP_RELEASE     = 3'd3,
    OP_RESERVE     = 3'd4
  } op_e_t;

  // Control states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_FINISH,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Index of the lowest clear bit of a byte (caller checks the byte is not full)
  function automatic logic [2:0] lowest_zero(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!b[j]) idx = 3'(j);
    end
    return idx;
  endfunction

endpackage

[sv/bfa_if.sv]
// Valid/ready channel interfaces for allocator requests and responses.
`timescale 1ns / 1ps

interface bfa_req_if;
  import bfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  length;

  modport source (output valid, operation, address, length, input ready);
  modport sink   (input valid, operation, address, length, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;
  logic            valid;
  logic            ready;
  logic [FA_W-1:0] frame_address;
  logic            found;

  modport source (output valid, frame_address, found, input ready);
  modport sink   (input valid, frame_address, found, output ready);
endinterface

[sv/bfa_store.sv]
// Bitmap store: byte-wide simple dual-port RAM, registered read.
`timescale 1ns / 1ps

module bfa_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/bitmap_frame_allocator_core.sv]
// First-fit bitmap allocator of 4 KiB frames: control, walk and scan logic.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+---------------------------------
//   req     | in  | valid/ready   | operation, address, length
//   rsp     | out | valid/ready   | frame_address, found
//   cfg     | in  | cfg_we        | cfg_wdata (bytes_in_use)
//
// One transaction at a time; the bitmap RAM port sets the pace at one byte a cycle.
// Allocate goes idle, scan, result; range ops go idle, setup, walk, finish, result,
// with empty ranges going from setup straight to result; unused codes go idle, result.
// After rst a clearing pass writes every byte to all-reserved.
// A waiting response does not block the next request; only a second result stalls.
`timescale 1ns / 1ps

module bitmap_frame_allocator_core #(
  parameter int BITMAP_BYTES = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata,
  bfa_req_if.sink                   req,
  bfa_rsp_if.source                 rsp
);
  import bfa_pkg::*;

  localparam int AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam logic [FRAME_W-1:0] LIMIT    = FRAME_W'(BITMAP_BYTES * 8);
  localparam logic [BYTE_W-1:0]  NBYTES   = BYTE_W'(BITMAP_BYTES);
  localparam logic [AW-1:0]      CLR_LAST = AW'(BITMAP_BYTES - 1);

  // Configuration register
  logic [CFG_W-1:0] bytes_in_use;
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      bytes_in_use <= cfg_wdata;
    end
  end

  logic [BYTE_W-1:0] active;
  assign active = (BYTE_W'(bytes_in_use) > NBYTES) ? NBYTES : BYTE_W'(bytes_in_use);

  // State and datapath registers
  state_t state, state_next;
  logic [AW-1:0]      clr_addr;
  logic [FRAME_W-1:0] first, last;
  logic               set_mode;
  logic [BYTE_W-1:0]  cur, end_byte;
  logic               p_valid;
  logic [BYTE_W-1:0]  p_byte;
  logic               res_found;
  logic [FA_W-1:0]    res_addr;

  // RAM controls
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  bfa_store #(.DEPTH(BITMAP_BYTES), .AW(AW)) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Range bounds at request time
  logic [FRAME_W-1:0] req_start;
  logic [ADDR_W:0]    req_sum;
  assign req_start = FRAME_W'(req.address[ADDR_W-1:PAGE_SHIFT]);
  assign req_sum   = {1'b0, req.address} + {1'b0, req.length};

  // Clipped end and walk setup
  logic [FRAME_W-1:0] last_clip, last_m1;
  assign last_clip = (last > LIMIT) ? LIMIT : last;
  assign last_m1   = last_clip - FRAME_W'(1);

  // Per-bit mask of the pending byte within [first, last)
  logic [7:0] mask;
  always_comb begin
    logic [FRAME_W-1:0] f;
    for (int j = 0; j < 8; j++) begin
      f = {p_byte, 3'(j)};
      mask[j] = (f >= first) && (f < last);
    end
  end

  logic       hit;
  logic [2:0] hit_bit;
  assign hit     = p_valid && (rd_data != BYTE_FULL);
  assign hit_bit = lowest_zero(rd_data);

  logic rsp_load;

  // Next state and RAM controls
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = p_byte[AW-1:0];
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = cur[AW-1:0];
    rsp_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = BYTE_FULL;
        if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          unique case (req.operation)
            OP_ALLOC: state_next = ST_SCAN;
            OP_FREE, OP_RESERVE_ALL, OP_RELEASE, OP_RESERVE: state_next = ST_SETUP;
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_SETUP: begin
        state_next = (last_clip > first) ? ST_WALK : ST_RESULT;
      end
      ST_WALK, ST_FINISH: begin
        // write back the byte read last cycle
        wr_en   = p_valid;
        wr_data = set_mode ? (rd_data | mask) : (rd_data & ~mask);
        if (state == ST_WALK) begin
          rd_en = 1'b1;
          if (cur == end_byte) state_next = ST_FINISH;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          wr_en      = 1'b1;
          wr_data    = rd_data | (8'b1 << hit_bit);
          state_next = ST_RESULT;
        end else if (cur < end_byte) begin
          rd_en = 1'b1;
        end else if (!p_valid) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!rsp.valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Pending read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (state == ST_SCAN && hit) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= rd_en;
    end
  end

  // Walk / scan datapath
  always_ff @(posedge clk) begin
    if (rd_en) begin
      p_byte <= cur;
      cur    <= cur + BYTE_W'(1);
    end
    if (state == ST_IDLE && req.valid) begin
      res_found <= 1'b0;
      res_addr  <= '0;
      cur       <= '0;
      end_byte  <= active;
      // reserve-all starts at byte 0; free and release clear bits
      first     <= (req.operation == OP_RESERVE_ALL) ? '0 : req_start;
      set_mode  <= (req.operation != OP_FREE) && (req.operation != OP_RELEASE);
      unique case (req.operation)
        OP_FREE: begin
          last <= req_start + FRAME_W'(1);
        end
        OP_RESERVE_ALL: begin
          last <= {active, 3'b000};
        end
        OP_RELEASE: begin
          last <= req_start + FRAME_W'(req.length[LEN_W-1:PAGE_SHIFT]);
        end
        OP_RESERVE: begin
          last <= req_sum[ADDR_W:PAGE_SHIFT];
        end
        default: begin
          last <= '0;
        end
      endcase
    end
    if (state == ST_SETUP) begin
      last     <= last_clip;
      cur      <= first[FRAME_W-1:3];
      end_byte <= last_m1[FRAME_W-1:3];
    end
    if (state == ST_SCAN && hit) begin
      res_found <= 1'b1;
      res_addr  <= {p_byte[FA_W-PAGE_SHIFT-4:0], hit_bit, {PAGE_SHIFT{1'b0}}};
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.found         <= res_found;
      rsp.frame_address <= res_addr;
    end
  end

endmodule

[tb/bfa_grant_checker.sv]
// Allocator response checker: mirrors the frame bitmap and compares every response.
`timescale 1ns / 1ps

module bfa_grant_checker #(
  parameter int BITMAP_BYTES = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata,
  bfa_req_if                        req,
  bfa_rsp_if                        rsp,
  output int                        fail_count,
  output int                        outstanding,
  output int                        checked_count,
  output int                        granted_count
);
  import bfa_pkg::*;

  typedef struct packed {
    logic [FA_W-1:0] frame_address;
    logic            found;
  } grant_t;

  localparam longint FRAME_LIMIT = longint'(BITMAP_BYTES) * 8;

  // Mirror of the frame bitmap and the search window register
  logic [7:0]       frame_map [BITMAP_BYTES];
  logic [CFG_W-1:0] bytes_in_use;
  grant_t           expected_grants [$];
  grant_t           oldest_grant;

  // Window that allocate searches and reserve-all fills
  function automatic int search_bytes();
    return (int'(bytes_in_use) > BITMAP_BYTES) ? BITMAP_BYTES : int'(bytes_in_use);
  endfunction

  // Set or clear frames [first, last); frames past the store are dropped
  function automatic void mark_frames(input longint first, input longint last,
                                      input logic val);
    longint stop;
    longint f;
    stop = (last > FRAME_LIMIT) ? FRAME_LIMIT : last;
    for (f = first; f < stop; f++) begin
      frame_map[int'(f >> 3)][int'(f & 7)] = val;
    end
  endfunction

  // Apply one transaction to the mirror and return the response it must produce
  function automatic grant_t predict_grant(input logic [OP_W-1:0]   op,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [LEN_W-1:0]  len);
    grant_t g;
    longint start;
    longint addr_q;
    longint len_q;
    int     n;
    g      = '0;
    addr_q = longint'({32'b0, addr});
    len_q  = longint'({32'b0, len});
    start  = addr_q >> PAGE_SHIFT;
    n      = search_bytes();
    case (op)
      OP_ALLOC: begin
        // first fit: lowest clear bit of the lowest non-full byte
        for (int i = 0; i < n && !g.found; i++) begin
          if (frame_map[i] != BYTE_FULL) begin
            for (int j = 0; j < 8 && !g.found; j++) begin
              if (!frame_map[i][j]) begin
                frame_map[i][j] = 1'b1;
                g.found         = 1'b1;
                g.frame_address = FA_W'(longint'(i * 8 + j) << PAGE_SHIFT);
              end
            end
          end
        end
      end
      OP_FREE:        mark_frames(start, start + 1, 1'b0);
      OP_RESERVE_ALL: for (int i = 0; i < n; i++) frame_map[i] = BYTE_FULL;
      OP_RELEASE:     mark_frames(start, start + (len_q >> PAGE_SHIFT), 1'b0);
      // end of range is taken from the carry-preserving sum
      OP_RESERVE:     mark_frames(start, (addr_q + len_q) >> PAGE_SHIFT, 1'b1);
      default: ;
    endcase
    return g;
  endfunction

  // Sample all channels at the rising edge; response first, then new transaction
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BITMAP_BYTES; i++) frame_map[i] = BYTE_FULL;
      bytes_in_use = CFG_RESET;
      expected_grants.delete();
      fail_count    = 0;
      checked_count = 0;
      granted_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          $error("response with no transaction outstanding: frame_address %h found %b",
                 rsp.frame_address, rsp.found);
          fail_count++;
        end else begin
          oldest_grant = expected_grants.pop_front();
          checked_count++;
          if (rsp.frame_address !== oldest_grant.frame_address) begin
            $error("frame_address mismatch: expected %h, actual %h",
                   oldest_grant.frame_address, rsp.frame_address);
            fail_count++;
          end
          if (rsp.found !== oldest_grant.found) begin
            $error("found mismatch: expected %b, actual %b", oldest_grant.found, rsp.found);
            fail_count++;
          end
          if (oldest_grant.found) granted_count++;
        end
      end
      if (cfg_we) bytes_in_use = cfg_wdata;
      if (req.valid && req.ready) begin
        expected_grants.push_back(predict_grant(req.operation, req.address, req.length));
      end
    end
    outstanding = expected_grants.size();
  end

endmodule

[tb/bitmap_frame_allocator_core_tb.sv]
// Testbench top for the frame allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module bitmap_frame_allocator_core_tb;
  import bfa_pkg::*;

  localparam int BITMAP_BYTES = 4096;
  localparam int PHASES       = 14;
  localparam int TIMEOUT_NS   = 50_000_000;
  localparam int DRAIN_CYCLES = 50;
  // codes the block must treat as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               fail_count;
  int               outstanding;
  int               checked_count;
  int               granted_count;
  int               burst_left;
  int               active_span;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  bitmap_frame_allocator_core #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  bfa_grant_checker #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .checked_count(checked_count),
    .granted_count(granted_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("bitmap_frame_allocator_core verification failed");
    $finish;
  end

  // Response backpressure: short stalls mostly, some long, some stall-free stretches
  initial begin : rsp_stall
    int mode;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 99);
      if (mode < 15) begin
        rsp_ch.ready = 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b0;
        repeat ((mode < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
        rsp_ch.ready = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
  end

  // Window size per random phase; extremes and out-of-range values included
  function automatic int phase_setting(input int p);
    case (p)
      0:       return 1;
      1:       return 8191;
      2:       return 3;
      3:       return 16;
      4:       return 0;
      5:       return 64;
      6:       return 4096;
      7:       return 8;
      8:       return 32;
      9:       return 200;
      10:      return 5;
      11:      return 12;
      12:      return 4097;
      default: return 48;
    endcase
  endfunction

  // Idle cycles before the next request
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      burst_left = $urandom_range(5, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Frame near the search window most of the time, anywhere around the store otherwise
  function automatic int pick_frame();
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, active_span + 15);
    return $urandom_range(0, BITMAP_BYTES * 8 + 63);
  endfunction

  // Drive one transaction and hold it until accepted
  task automatic send_request(input logic [OP_W-1:0]   op,
                              input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0]  len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     = 1'b1;
    req_ch.operation = op;
    req_ch.address   = addr;
    req_ch.length    = len;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Register write once every response is back
  task automatic set_bytes_in_use(input int value);
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we      = 1'b1;
    cfg_wdata   = CFG_W'(value);
    active_span = ((value > BITMAP_BYTES) ? BITMAP_BYTES : value) * 8;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly well-formed ops on frames near the window, some full-width noise
  task automatic send_random_item();
    int                r;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    r    = $urandom_range(0, 99);
    addr = (ADDR_W'(pick_frame()) << PAGE_SHIFT) | ADDR_W'($urandom_range(0, 4095));
    len  = (LEN_W'($urandom_range(0, 24)) << PAGE_SHIFT) | LEN_W'($urandom_range(0, 4095));
    if (r < 35)      send_request(OP_ALLOC, $urandom, $urandom);
    else if (r < 55) send_request(OP_FREE, addr, $urandom);
    else if (r < 70) send_request(OP_RELEASE, addr, len);
    else if (r < 85) send_request(OP_RESERVE, addr, len);
    else if (r < 88) send_request(OP_RESERVE_ALL, $urandom, $urandom);
    else if (r < 91) send_request(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                                  $urandom, $urandom);
    else             send_request(OP_W'($urandom_range(0, (1 << OP_W) - 1)),
                                  $urandom, $urandom);
  endtask

  // Main sequence
  initial begin
    int code;
    int setting;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_ALLOC;
    req_ch.address   = '0;
    req_ch.length    = '0;
    burst_left       = 0;
    active_span      = BITMAP_BYTES * 8;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: reset window, store starts fully reserved
    send_request(OP_ALLOC, 32'h0, 32'h0);                      // nothing free
    send_request(OP_RELEASE, 32'h0, 32'h0000_0FFF);            // empty release
    send_request(OP_RELEASE, 32'h0, 32'h0001_0000);            // frames 0..15
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);      // frame zero
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_FREE, 32'h0000_0FFF, 32'h0);               // unaligned free of frame 0
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_RESERVE, 32'h0000_2000, 32'h0000_3000);    // frames 2..4
    send_request(OP_RESERVE, 32'h0000_5064, 32'h0000_0064);    // end not above start
    send_request(OP_ALLOC, 32'h0, 32'h0);
    send_request(OP_FREE, 32'h0800_0000, 32'h0);               // first frame past the store
    send_request(OP_FREE, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF);    // sum carries out of 32 bits
    send_request(OP_RELEASE, 32'h07FF_F000, 32'hFFFF_FFFF);    // clipped to the last frame
    for (code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++) begin
      send_request(OP_W'(code), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end
    send_request(OP_RESERVE, 32'h0, 32'hFFFF_FFFF);            // whole store
    send_request(OP_RELEASE, 32'h07FF_8000, 32'h0000_8000);    // top eight frames
    send_request(OP_ALLOC, 32'h0, 32'h0);                      // lowest of the top eight frames
    send_request(OP_RESERVE_ALL, 32'h0, 32'h0);
    send_request(OP_ALLOC, 32'h0, 32'h0);

    // Directed: empty window, then a one-byte window
    set_bytes_in_use(0);
    send_request(OP_RELEASE, 32'h0, 32'h0000_8000);
    send_request(OP_ALLOC, 32'h0, 32'h0);                      // window empty: nothing found
    set_bytes_in_use(1);
    send_request(OP_ALLOC, 32'h0, 32'h0);

    // Random phases; large windows get fewer transactions since scans are long
    for (int p = 0; p < PHASES; p++) begin
      setting = phase_setting(p);
      set_bytes_in_use(setting);
      repeat ((setting >= 200) ? 50 : 120) send_random_item();
    end

    // Drain
    req_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d responses across %0d window settings, %0d frames granted",
             checked_count, PHASES + 3, granted_count);
    if (fail_count == 0) begin
      $display("bitmap_frame_allocator_core verification clean");
    end else begin
      $display("bitmap_frame_allocator_core verification failed");
    end
    $finish;
  end

endmodule
